[rtl/core/b64lw_pkg.sv]
// Shared types and constants for the base64 codec with line wrap.
// Used by the front, queue, back and top-level modules; no dependencies.
package b64lw_pkg;

  localparam int unsigned JobBytes = 6;
  localparam int unsigned CntW     = 3;

  localparam logic [1:0] CfgDirMode  = 2'd0;
  localparam logic [1:0] CfgWrapEn   = 2'd1;
  localparam logic [1:0] CfgLineChar = 2'd2;

  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } b64lw_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_empty;
    logic       out_last;
  } b64lw_out_t;

  typedef struct packed {
    logic       dir_mode;
    logic       wrap_en;
    logic [7:0] line_chars;
  } b64lw_cfg_t;

  typedef struct packed {
    logic [JobBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          count;
    logic                     last;
    logic                     empty;
  } b64lw_job_t;

endpackage

[rtl/core/b64lw_front.sv]
// Front end: accepts input beats, holds group/line state, builds one job per beat.
// Depends on b64lw_pkg for the payload, configuration and job types.
module b64lw_front import b64lw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  b64lw_cfg_t cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  b64lw_in_t  in_i,
  input  logic       full_i,
  output logic       push_o,
  output b64lw_job_t job_o
);

  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChPad = 8'h3D;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'(v) + 8'd65;
    end else if (v < 6'd52) begin
      r = 8'(v) + 8'd71;
    end else if (v < 6'd62) begin
      r = 8'(v) - 8'd4;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

  function automatic logic [5:0] dec_value(input logic [7:0] c);
    logic [5:0] r;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = 6'(c - 8'd71);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = 6'(c + 8'd4);
    end else if (c == 8'h2B) begin
      r = 6'd62;
    end else if (c == 8'h2F) begin
      r = 6'd63;
    end else begin
      r = 6'd0;
    end
    return r;
  endfunction

  logic [23:0] gb_q, gb_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [7:0]  col_q, col_d;
  logic        pad_q, pad_d;
  logic        accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept && (job_o.count != '0);

  always_comb begin
    logic [23:0]   shifted;
    logic [23:0]   v;
    logic [1:0]    cnt_new;
    logic [8:0]    col;
    logic [CntW-1:0] n;
    logic [7:0]    c;
    c       = in_i.in_byte;
    gb_d    = gb_q;
    cnt_d   = cnt_q;
    col_d   = col_q;
    pad_d   = pad_q;
    n       = '0;
    job_o   = '0;
    shifted = {gb_q[15:0], c};
    v       = '0;
    cnt_new = cnt_q + 2'd1;
    col     = {1'b0, col_q} + 9'd4;
    if (cfg_i.dir_mode == ModeEncode) begin
      if (cnt_q >= 2'd2) begin
        job_o.bytes[0] = enc_char(shifted[23:18]);
        job_o.bytes[1] = enc_char(shifted[17:12]);
        job_o.bytes[2] = enc_char(shifted[11:6]);
        job_o.bytes[3] = enc_char(shifted[5:0]);
        n     = 3'd4;
        gb_d  = '0;
        cnt_d = '0;
        if (cfg_i.wrap_en && col >= {1'b0, cfg_i.line_chars}) begin
          job_o.bytes[4] = ChCr;
          job_o.bytes[5] = ChLf;
          n   = 3'd6;
          col = '0;
        end
        col_d = col[7:0];
      end else begin
        gb_d  = shifted;
        cnt_d = cnt_new;
        if (in_i.in_last) begin
          v = (cnt_new == 2'd1) ? {shifted[7:0], 16'h0000} : {shifted[15:0], 8'h00};
          job_o.bytes[0] = enc_char(v[23:18]);
          job_o.bytes[1] = enc_char(v[17:12]);
          job_o.bytes[2] = (cnt_new == 2'd2) ? enc_char(v[11:6]) : ChPad;
          job_o.bytes[3] = ChPad;
          n = 3'd4;
        end
      end
    end else begin
      if (c == ChCr || c == ChLf || pad_q) begin
        n = '0;
      end else if (c == ChPad) begin
        if (cnt_q == 2'd2) begin
          job_o.bytes[0] = gb_q[11:4];
          n = 3'd1;
        end else if (cnt_q == 2'd3) begin
          job_o.bytes[0] = gb_q[17:10];
          job_o.bytes[1] = gb_q[9:2];
          n = 3'd2;
        end
        gb_d  = '0;
        cnt_d = '0;
        pad_d = 1'b1;
      end else begin
        gb_d = {gb_q[17:0], dec_value(c)};
        if (cnt_q == 2'd3) begin
          job_o.bytes[0] = gb_d[23:16];
          job_o.bytes[1] = gb_d[15:8];
          job_o.bytes[2] = gb_d[7:0];
          n     = 3'd3;
          gb_d  = '0;
          cnt_d = '0;
        end else begin
          cnt_d = cnt_new;
        end
      end
      if (in_i.in_last && n == '0) begin
        if (cnt_d == 2'd2) begin
          job_o.bytes[0] = gb_d[11:4];
          n = 3'd1;
        end else if (cnt_d == 2'd3) begin
          job_o.bytes[0] = gb_d[17:10];
          job_o.bytes[1] = gb_d[9:2];
          n = 3'd2;
        end
      end
    end
    if (in_i.in_last) begin
      gb_d  = '0;
      cnt_d = '0;
      col_d = '0;
      pad_d = 1'b0;
      if (n == '0) begin
        n           = 3'd1;
        job_o.empty = 1'b1;
      end
    end
    job_o.count = n;
    job_o.last  = in_i.in_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gb_q  <= '0;
      cnt_q <= '0;
      col_q <= '0;
      pad_q <= 1'b0;
    end else if (accept) begin
      gb_q  <= gb_d;
      cnt_q <= cnt_d;
      col_q <= col_d;
      pad_q <= pad_d;
    end
  end

endmodule

[rtl/core/b64lw_queue.sv]
// Two-entry job queue between the front end and the output serializer.
// Depends on b64lw_pkg for the job type.
module b64lw_queue import b64lw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  b64lw_job_t job_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output b64lw_job_t job_o
);

  b64lw_job_t entries_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign job_o   = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

[rtl/core/b64lw_back.sv]
// Output serializer: walks the head job one byte per beat into an output register.
// Depends on b64lw_pkg for the job and result types.
module b64lw_back import b64lw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  b64lw_job_t job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output b64lw_out_t out_o
);

  logic [CntW-1:0] idx_q;
  logic            out_valid_q;
  b64lw_out_t      out_q;
  logic            load, take, at_end;

  assign load        = !out_valid_q || out_ready_i;
  assign take        = load && valid_i;
  assign at_end      = (idx_q == job_i.count - 3'd1);
  assign pop_o       = take && at_end;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q.out_byte  <= job_i.bytes[idx_q];
      out_q.out_empty <= job_i.empty;
      out_q.out_last  <= job_i.last && at_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= valid_i;
      end
      if (take) begin
        idx_q <= at_end ? '0 : idx_q + 3'd1;
      end
    end
  end

endmodule

[rtl/core/base64_codec_line_wrap.sv]
// Base64 codec with MIME line wrap: front end, two-entry job queue, output serializer.
// The first result byte of a beat passes through a queue entry and then the output register.
// Throughput: one beat per cycle while the job queue has room; results leave one byte per
// cycle while the receiver is ready, and each job holds up to 6 bytes.
// Reset: group, line and pad state and the queue clear; registers return to encode,
// wrap on, 76 characters per line. Depends on b64lw_pkg.
module base64_codec_line_wrap import b64lw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  b64lw_in_t  in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output b64lw_out_t out_o
);

  b64lw_cfg_t cfg_q;
  b64lw_job_t push_job, head_job;
  logic       push, full, pop, head_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dir_mode   <= ModeEncode;
      cfg_q.wrap_en    <= 1'b1;
      cfg_q.line_chars <= 8'd76;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgDirMode:  cfg_q.dir_mode   <= cfg_data_i[0];
        CfgWrapEn:   cfg_q.wrap_en    <= cfg_data_i[0];
        CfgLineChar: cfg_q.line_chars <= cfg_data_i;
        default: ;
      endcase
    end
  end

  b64lw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .full_i     (full),
    .push_o     (push),
    .job_o      (push_job)
  );

  b64lw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .job_o   (head_job)
  );

  b64lw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (head_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

[verif/base64_codec_line_wrap_test.sv]
// Self-checking testbench for base64_codec_line_wrap: encode, decode, line wrap and stalls.
// Predicts every output beat from its own copy of the codec state and checks it in order.
// Depends on b64lw_pkg and the base64_codec_line_wrap RTL.
`timescale 1ns / 1ps

module base64_codec_line_wrap_test;
  import b64lw_pkg::*;

  localparam int DrainCycles  = 8;
  localparam int RxHoldCycles = 300;
  localparam int TimeoutNs    = 5_000_000;
  localparam int MaxReports   = 10;

  localparam logic [7:0] CharCR  = 8'h0D;
  localparam logic [7:0] CharLF  = 8'h0A;
  localparam logic [7:0] CharPad = 8'h3D;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i  = '0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  b64lw_in_t  in_i        = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  b64lw_out_t out_o;

  base64_codec_line_wrap dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .in_i,
    .out_valid_o,
    .out_ready_i,
    .out_o
  );

  // Codec copy: registers and group state.
  logic        dir_mode = ModeEncode;
  logic        wrap_en  = 1'b1;
  logic [7:0]  line_max = 8'd76;
  logic [23:0] grp_bits = '0;
  logic [1:0]  grp_cnt  = '0;
  logic [7:0]  line_col = '0;
  logic        pad_hit  = 1'b0;

  logic [7:0] step_bytes[$];
  b64lw_out_t codec_out_q[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic rx_hold = 1'b0;
  int fail_count = 0;
  int beats_in = 0;
  int beats_out = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [7:0] sextet_char(logic [5:0] s);
    if (s < 6'd26) return 8'h41 + {2'b00, s};
    if (s < 6'd52) return 8'h61 + {2'b00, s} - 8'd26;
    if (s < 6'd62) return 8'h30 + {2'b00, s} - 8'd52;
    if (s == 6'd62) return 8'h2B;
    return 8'h2F;
  endfunction

  function automatic logic [5:0] char_sextet(logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return 6'(c - 8'h41);
    if (c >= 8'h61 && c <= 8'h7A) return 6'(c - 8'h61 + 8'd26);
    if (c >= 8'h30 && c <= 8'h39) return 6'(c - 8'h30 + 8'd52);
    if (c == 8'h2B) return 6'd62;
    if (c == 8'h2F) return 6'd63;
    return 6'd0;
  endfunction

  function automatic void flush_quartet();
    logic [23:0] v;
    v = grp_bits << (6 * (4 - int'(grp_cnt)));
    if (grp_cnt >= 2'd2) step_bytes.push_back(v[23:16]);
    if (grp_cnt == 2'd3) step_bytes.push_back(v[15:8]);
    grp_bits = '0;
    grp_cnt  = '0;
  endfunction

  function automatic void predict_codec_out(b64lw_in_t beat);
    logic [7:0]  c;
    logic [23:0] v;
    logic [8:0]  nxt;
    b64lw_out_t  r;
    c = beat.in_byte;
    step_bytes.delete();
    if (dir_mode == ModeEncode) begin
      grp_bits = {grp_bits[15:0], c};
      if (grp_cnt >= 2'd2) begin
        step_bytes.push_back(sextet_char(grp_bits[23:18]));
        step_bytes.push_back(sextet_char(grp_bits[17:12]));
        step_bytes.push_back(sextet_char(grp_bits[11:6]));
        step_bytes.push_back(sextet_char(grp_bits[5:0]));
        grp_bits = '0;
        grp_cnt  = '0;
        nxt = {1'b0, line_col} + 9'd4;
        if (wrap_en && nxt >= {1'b0, line_max}) begin
          step_bytes.push_back(CharCR);
          step_bytes.push_back(CharLF);
          nxt = '0;
        end
        line_col = nxt[7:0];
      end else begin
        grp_cnt = grp_cnt + 2'd1;
        if (beat.in_last) begin
          v = (grp_cnt == 2'd1) ? {grp_bits[7:0], 16'h0000} : {grp_bits[15:0], 8'h00};
          step_bytes.push_back(sextet_char(v[23:18]));
          step_bytes.push_back(sextet_char(v[17:12]));
          step_bytes.push_back((grp_cnt == 2'd2) ? sextet_char(v[11:6]) : CharPad);
          step_bytes.push_back(CharPad);
        end
      end
    end else begin
      if (!(c == CharCR || c == CharLF || pad_hit)) begin
        if (c == CharPad) begin
          flush_quartet();
          pad_hit = 1'b1;
        end else begin
          grp_bits = {grp_bits[17:0], char_sextet(c)};
          if (grp_cnt == 2'd3) begin
            step_bytes.push_back(grp_bits[23:16]);
            step_bytes.push_back(grp_bits[15:8]);
            step_bytes.push_back(grp_bits[7:0]);
            grp_bits = '0;
            grp_cnt  = '0;
          end else begin
            grp_cnt = grp_cnt + 2'd1;
          end
        end
      end
      if (beat.in_last) flush_quartet();
    end
    if (beat.in_last) begin
      grp_bits = '0;
      grp_cnt  = '0;
      line_col = '0;
      pad_hit  = 1'b0;
    end
    if (beat.in_last && step_bytes.size() == 0) begin
      r = '{out_byte: 8'h00, out_empty: 1'b1, out_last: 1'b1};
      codec_out_q.push_back(r);
    end else begin
      foreach (step_bytes[k]) begin
        r = '{out_byte: step_bytes[k], out_empty: 1'b0,
              out_last: beat.in_last && (k == step_bytes.size() - 1)};
        codec_out_q.push_back(r);
      end
    end
  endfunction

  // Receiver: random stalls, forced low while a hold-off runs.
  always @(posedge clk_i) begin
    out_ready_i <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    forever begin
      wait (rx_hold);
      repeat (RxHoldCycles) @(posedge clk_i);
      rx_hold <= 1'b0;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_out
    b64lw_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_out++;
      if (codec_out_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("unexpected beat: byte %h empty %b last %b",
                   out_o.out_byte, out_o.out_empty, out_o.out_last);
      end else begin
        want = codec_out_q.pop_front();
        if (out_o.out_empty !== want.out_empty || out_o.out_last !== want.out_last ||
            (!want.out_empty && out_o.out_byte !== want.out_byte)) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("mismatch: expected byte %h empty %b last %b, got byte %h empty %b last %b",
                     want.out_byte, want.out_empty, want.out_last,
                     out_o.out_byte, out_o.out_empty, out_o.out_last);
        end
      end
    end
  end

  task automatic send_beat(input b64lw_in_t beat);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    predict_codec_out(beat);
    beats_in++;
  endtask

  task automatic send_message(input logic [7:0] chars[$]);
    b64lw_in_t beat;
    foreach (chars[k]) begin
      beat.in_byte = chars[k];
      beat.in_last = (k == chars.size() - 1);
      send_beat(beat);
    end
  endtask

  // Drop valid, wait for every expected beat, then let the pipeline empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (codec_out_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgDirMode:  dir_mode = val[0];
      CfgWrapEn:   wrap_en  = val[0];
      CfgLineChar: line_max = val;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_encode_tail();
    send_message('{8'h00});
    send_message('{8'hFF, 8'h80});
    settle();
  endtask

  task automatic test_line_wrap_edge();
    write_reg(CfgLineChar, 8'd4);
    send_message('{8'h12, 8'h34, 8'h56});
    settle();
  endtask

  task automatic test_decode_rules();
    write_reg(CfgDirMode, {7'b0, ModeDecode});
    // quartet with a non-alphabet char, CR LF, pad after one char, ignored tail
    send_message('{8'h2F, 8'h2B, 8'h39, 8'h2A, CharCR, CharLF, 8'h7A, CharPad, 8'h51, 8'h78});
    // unpadded tail
    send_message('{8'h51, 8'h55, 8'h4A});
    settle();
  endtask

  task automatic test_mode_switch();
    b64lw_in_t beat;
    write_reg(CfgDirMode, {7'b0, ModeEncode});
    beat = '{in_byte: 8'hA5, in_last: 1'b0};
    send_beat(beat);
    settle();
    write_reg(CfgDirMode, {7'b0, ModeDecode});
    send_message('{8'h42, 8'h43, 8'h44});
    settle();
  endtask

  task automatic test_random_encode(input int n_beats, input int max_len);
    logic [7:0] chars[$];
    int sent;
    sent = 0;
    while (sent < n_beats) begin
      chars.delete();
      repeat ($urandom_range(1, max_len)) chars.push_back(8'($urandom));
      send_message(chars);
      sent += chars.size();
    end
    settle();
  endtask

  task automatic test_random_decode(input int n_beats);
    logic [7:0]  chars[$];
    logic [7:0]  raw[$];
    logic [23:0] bits;
    int sent, nbytes, rem;
    bit pad_on;
    sent = 0;
    while (sent < n_beats) begin
      chars.delete();
      raw.delete();
      if ($urandom_range(9) < 8) begin
        nbytes = $urandom_range(1, 9);
        pad_on = ($urandom_range(3) != 0);
        repeat (nbytes) raw.push_back(8'($urandom));
        raw.push_back(8'h00);
        raw.push_back(8'h00);
        for (int i = 0; i < nbytes; i += 3) begin
          rem  = nbytes - i;
          bits = {raw[i], (rem > 1) ? raw[i+1] : 8'h00, (rem > 2) ? raw[i+2] : 8'h00};
          chars.push_back(sextet_char(bits[23:18]));
          chars.push_back(sextet_char(bits[17:12]));
          if (rem > 1) chars.push_back(sextet_char(bits[11:6]));
          else if (pad_on) chars.push_back(CharPad);
          if (rem > 2) chars.push_back(sextet_char(bits[5:0]));
          else if (pad_on) chars.push_back(CharPad);
          if (rem > 3 && $urandom_range(3) == 0) begin
            chars.push_back(CharCR);
            chars.push_back(CharLF);
          end
        end
        if (pad_on && $urandom_range(4) == 0)
          repeat ($urandom_range(1, 3)) chars.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 10))
          chars.push_back(($urandom_range(5) == 0) ? CharPad : 8'($urandom));
      end
      send_message(chars);
      sent += chars.size();
    end
    settle();
  endtask

  task automatic test_output_backpressure();
    logic [7:0] chars[$];
    write_reg(CfgDirMode, {7'b0, ModeEncode});
    write_reg(CfgWrapEn, 8'd1);
    write_reg(CfgLineChar, 8'd16);
    rx_hold <= 1'b1;
    repeat (3) begin
      chars.delete();
      repeat (12) chars.push_back(8'($urandom));
      send_message(chars);
    end
    settle();
  endtask

  task automatic test_long_line();
    logic [7:0] chars[$];
    write_reg(CfgLineChar, 8'd252);
    repeat (195) chars.push_back(8'($urandom));
    send_message(chars);
    settle();
  endtask

  initial begin
    #(TimeoutNs);
    $display("timeout with %0d beats still expected", codec_out_q.size());
    $display("FAIL base64_codec_line_wrap");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 20;
    rx_idle_pct = 57;
    test_encode_tail();
    test_line_wrap_edge();
    test_decode_rules();
    test_mode_switch();

    write_reg(CfgDirMode, {7'b0, ModeEncode});
    write_reg(CfgLineChar, 8'd8);
    test_random_encode(30, 12);
    write_reg(CfgDirMode, {7'b0, ModeDecode});
    test_random_decode(25);

    tx_idle_pct = 57;
    rx_idle_pct = 20;
    write_reg(CfgDirMode, {7'b0, ModeEncode});
    write_reg(CfgWrapEn, 8'd0);
    write_reg(CfgLineChar, 8'd12);
    test_random_encode(15, 10);
    write_reg(CfgWrapEn, 8'd1);
    write_reg(CfgLineChar, 8'd6);
    test_random_encode(15, 10);
    write_reg(CfgDirMode, {7'b0, ModeDecode});
    write_reg(CfgLineChar, 8'd255);
    test_random_decode(20);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_output_backpressure();
    test_long_line();

    $display("Run: %0d input beats and %0d output beats checked", beats_in, beats_out);
    $display("Covered pad tails, wrap at 4/6/8/16/252 and off, decode noise, mode switch, stall");
    if (fail_count == 0) begin
      $display("PASS base64_codec_line_wrap");
    end else begin
      $display("FAIL base64_codec_line_wrap");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/b64lw_pkg.sv
rtl/core/b64lw_front.sv
rtl/core/b64lw_queue.sv
rtl/core/b64lw_back.sv
rtl/core/base64_codec_line_wrap.sv
verif/base64_codec_line_wrap_test.sv
